@@ hdl/hbd_pkg.sv @@
`default_nettype none
package hbd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int NCOEF      = 7;
  localparam int HIST_DEPTH = 10;
  localparam int CFG_IDX_W  = 3;

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int S2_W   = PROD_W + 1;
  localparam int S3_W   = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SHIFT  = COEF_W - 1;
  localparam int RND_W  = ACC_W - SHIFT;

  // window position of each coefficient register, in register order
  localparam int TAP_POS [NCOEF] = '{0, 2, 4, 5, 6, 8, 10};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // real part in the low bits, matches the stream packing
  typedef struct packed {
    sample_t im;
    sample_t re;
  } cplx_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
    logic out_en;
  } pipe_ctl_t;

endpackage
`default_nettype wire

@@ hdl/hbd_cell.sv @@
`default_nettype none
module hbd_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire hbd_pkg::cplx_t sample_in,
  output hbd_pkg::cplx_t     sample_out
);
  import hbd_pkg::*;

  cplx_t sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift_en) begin
      sample_r <= sample_in;
    end
  end

  assign sample_out = sample_r;

endmodule
`default_nettype wire

@@ hdl/hbd_tap.sv @@
`default_nettype none
module hbd_tap (
  input  wire logic          clk,
  input  wire logic          load_en,
  input  wire hbd_pkg::coef_t coef,
  input  wire hbd_pkg::cplx_t sample,
  output hbd_pkg::prod_t     prod_re,
  output hbd_pkg::prod_t     prod_im
);
  import hbd_pkg::*;

  prod_t prod_re_r;
  prod_t prod_im_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      prod_re_r <= PROD_W'(coef) * PROD_W'(sample.re);
      prod_im_r <= PROD_W'(coef) * PROD_W'(sample.im);
    end
  end

  assign prod_re = prod_re_r;
  assign prod_im = prod_im_r;

endmodule
`default_nettype wire

@@ hdl/hbd_sum.sv @@
`default_nettype none
module hbd_sum (
  input  wire logic            clk,
  input  wire hbd_pkg::pipe_ctl_t ctl,
  input  wire hbd_pkg::prod_t  prod [hbd_pkg::NCOEF],
  output hbd_pkg::sample_t     result
);
  import hbd_pkg::*;

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(2 ** (SHIFT - 1));

  logic signed [S2_W-1:0]  s2_r [4];
  logic signed [S3_W-1:0]  s3_r [2];
  logic signed [ACC_W-1:0] acc_r;
  sample_t                 result_r;
  logic signed [ACC_W-1:0] rnd;
  logic signed [RND_W-1:0] shifted;
  sample_t                 sat;

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      s2_r[0] <= S2_W'(prod[0]) + S2_W'(prod[1]);
      s2_r[1] <= S2_W'(prod[2]) + S2_W'(prod[3]);
      s2_r[2] <= S2_W'(prod[4]) + S2_W'(prod[5]);
      s2_r[3] <= S2_W'(prod[6]);
    end
    if (ctl.s3_en) begin
      s3_r[0] <= S3_W'(s2_r[0]) + S3_W'(s2_r[1]);
      s3_r[1] <= S3_W'(s2_r[2]) + S3_W'(s2_r[3]);
    end
    if (ctl.s4_en) begin
      acc_r <= ACC_W'(s3_r[0]) + ACC_W'(s3_r[1]);
    end
    if (ctl.out_en) begin
      result_r <= sat;
    end
  end

  // round half up, floor shift, saturate
  always_comb begin
    rnd     = acc_r + HALF;
    shifted = rnd[ACC_W-1:SHIFT];
    if (shifted > SAT_HI) begin
      sat = SAT_HI[SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  assign result = result_r;

endmodule
`default_nettype wire

@@ hdl/halfband_11tap_decimator.sv @@
// complex 11-tap halfband decimate-by-2, one tap cell chain for the history
// throughput: one input sample per cycle while in_tready is high, one result per two input samples
// a result reaches out_tvalid through the tap multiply register, three adder tree
// stages and the round and saturate register
// reset: synchronous active low rst_n clears the history, the coefficients and
// the pair phase (the next sample emits) and empties the pipeline
`default_nettype none
module halfband_11tap_decimator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [2*hbd_pkg::SAMPLE_W-1:0] in_tdata,   // in_real, in_imag
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [2*hbd_pkg::SAMPLE_W-1:0]     out_tdata,  // out_real, out_imag
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hbd_pkg::COEF_W-1:0]    cfg_data
);
  import hbd_pkg::*;

  coef_t     coef_r [NCOEF];
  logic      phase_r;
  logic      v1_r, v2_r, v3_r, v4_r, vo_r;
  logic      rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic      accept;
  pipe_ctl_t ctl;
  cplx_t     in_sample;
  cplx_t     win [HIST_DEPTH+1];
  prod_t     prod_re [NCOEF];
  prod_t     prod_im [NCOEF];
  sample_t   res_re, res_im;

  assign in_sample            = cplx_t'(in_tdata);
  assign win[HIST_DEPTH]      = in_sample;

  // each stage loads when empty or when its contents move on
  assign rdy_o = !vo_r || out_tready;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;

  // the second sample of a pair only shifts history
  assign in_tready = rdy1 || phase_r;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign ctl.s1_en  = rdy1;
  assign ctl.s2_en  = rdy2;
  assign ctl.s3_en  = rdy3;
  assign ctl.s4_en  = rdy4;
  assign ctl.out_en = rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      vo_r    <= 1'b0;
      for (int k = 0; k < NCOEF; k++) begin
        coef_r[k] <= '0;
      end
    end else begin
      if (accept) begin
        phase_r <= !phase_r;
      end
      if (rdy1) begin
        v1_r <= accept && !phase_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy_o) begin
        vo_r <= v4_r;
      end
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NCOEF))) begin
        coef_r[cfg_index] <= cfg_data;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < HIST_DEPTH; gi++) begin : g_cell
      hbd_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (accept),
        .sample_in  (win[gi+1]),
        .sample_out (win[gi])
      );
    end
    for (gi = 0; gi < NCOEF; gi++) begin : g_tap
      hbd_tap u_tap (
        .clk     (clk),
        .load_en (ctl.s1_en),
        .coef    (coef_r[gi]),
        .sample  (win[TAP_POS[gi]]),
        .prod_re (prod_re[gi]),
        .prod_im (prod_im[gi])
      );
    end
  endgenerate

  hbd_sum u_sum_re (
    .clk    (clk),
    .ctl    (ctl),
    .prod   (prod_re),
    .result (res_re)
  );

  hbd_sum u_sum_im (
    .clk    (clk),
    .ctl    (ctl),
    .prod   (prod_im),
    .result (res_im)
  );

  assign out_tvalid = vo_r;
  assign out_tdata  = {res_im, res_re};

endmodule
`default_nettype wire
